// File: rtl/per_bin_min_max_mean_stats_macros.svh
// ---------------------------------------------------------------------------
// per_bin_min_max_mean_stats_macros.svh
// Assertion macros used by the statistics block's checker.
// ---------------------------------------------------------------------------
`ifndef PER_BIN_MIN_MAX_MEAN_STATS_MACROS_SVH
`define PER_BIN_MIN_MAX_MEAN_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PBMMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbmms same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PBMMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbmms next-cycle check failed");

`endif

// File: rtl/pbmms_pkg.sv
// ---------------------------------------------------------------------------
// pbmms_pkg
// Constants and the control state type of the binned statistics block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbmms_pkg;

	// Item kinds on the input tuser bit
	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	// Bin layout
	localparam logic [3:0] FIRST_MONTH = 4'd1;
	localparam logic [3:0] LAST_MONTH  = 4'd12;

	// Start values of the running extremes
	localparam logic signed [7:0] MIN_START = 8'sd99;
	localparam logic signed [7:0] MAX_START = -8'sd99;

	// Field widths fixed by the item formats
	localparam int TEMP_W  = 8;
	localparam int OCNT_W  = 16;
	localparam int QUO_W   = 8;

	// Control sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_LOOKUP,
		ST_DIV,
		ST_PUT
	} state_t;

endpackage

// File: rtl/per_bin_min_max_mean_stats.sv
// ---------------------------------------------------------------------------
// per_bin_min_max_mean_stats
// Running count, sum, minimum and maximum of temperature samples in one year
// bin (bin 0) and twelve month bins, with per-bin reports of count, mean,
// minimum and maximum.
//
// Each bin lives in one entry of a single-port-read, single-port-write
// memory with a registered read; per-entry valid bits make an unwritten
// entry read as an empty bin, so no clearing pass is needed after reset.
// A record item is read-modify-written first into the year bin and then,
// if its month is in range, into its month bin. A report of a filled bin
// forms its mean with the 8-step restoring divider; a report of an empty
// or unknown bin skips the divider. A report result waits in the output
// register while the next items are taken; a second report stalls only if
// the first result is still not taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_bin_min_max_mean_stats
	import pbmms_pkg::*;
#(
	parameter int NUM_BINS    = 13,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // month[3:0], temperature[11:4], bin_select[15:12]
	input  logic        s_axis_tuser,  // action[0]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // sample_count[15:0], average_value[23:16],
	                                   // min_value[31:24], max_value[39:32]
	output logic        m_axis_tuser   // bin_empty[0]
);

	localparam int AW      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int SUM_W   = COUNT_WIDTH + TEMP_W;
	localparam int ENTRY_W = SUM_W + COUNT_WIDTH + 2 * TEMP_W;
	// Entry layout from the top: sum, count, min, max
	localparam int MAX_LO  = 0;
	localparam int MIN_LO  = TEMP_W;
	localparam int CNT_LO  = 2 * TEMP_W;
	localparam int SUM_LO  = CNT_LO + COUNT_WIDTH;
	localparam logic [6:0] NUM_BINS_C = 7'(NUM_BINS);
	localparam logic [AW-1:0] YEAR_ADDR = '0;
	localparam logic [$clog2(QUO_W)-1:0] LAST_STEP = '1;

	// Input item fields
	logic        [3:0]        in_month;
	logic signed [TEMP_W-1:0] in_temp;
	logic        [3:0]        in_sel;
	logic                     in_accept;
	logic                     in_month_ok;
	logic                     in_sel_ok;

	// Item registers
	logic        [AW-1:0]     month_addr_q;
	logic                     month_ok_q;
	logic                     sel_ok_q;
	logic signed [TEMP_W-1:0] temp_q;

	// Sequencer
	state_t state_q, state_d;

	// Memory and its valid bits
	logic [ENTRY_W-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rdata_s1;
	logic               rvld_s1;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wdata;

	// Current entry, updated entry
	logic signed [SUM_W-1:0]       cur_sum;
	logic        [COUNT_WIDTH-1:0] cur_cnt;
	logic signed [TEMP_W-1:0]      cur_min;
	logic signed [TEMP_W-1:0]      cur_max;
	logic                          cur_sat;
	logic signed [SUM_W-1:0]       new_sum;
	logic signed [TEMP_W-1:0]      new_min;
	logic signed [TEMP_W-1:0]      new_max;

	// Report path
	logic                          lookup_empty;
	logic        [SUM_W-1:0]       sum_mag;
	logic        [COUNT_WIDTH-1:0] rep_cnt_q;
	logic signed [TEMP_W-1:0]      rep_min_q;
	logic signed [TEMP_W-1:0]      rep_max_q;
	logic                          rep_empty_q;
	logic                          rep_neg_q;
	logic        [SUM_W-1:0]       rem_q;
	logic        [SUM_W-1:0]       dvs_q;
	logic        [QUO_W-1:0]       quo_q;
	logic        [$clog2(QUO_W)-1:0] step_q;
	logic                          rem_ge;
	logic signed [TEMP_W-1:0]      avg;

	// Output register
	logic        out_free;
	logic        out_load;
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic        m_tuser_q;

	// Input unpacking and range checks
	assign in_month  = s_axis_tdata[3:0];
	assign in_temp   = s_axis_tdata[11:4];
	assign in_sel    = s_axis_tdata[15:12];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign in_month_ok = (in_month >= FIRST_MONTH) && (in_month <= LAST_MONTH) &&
		({3'b000, in_month} < NUM_BINS_C);
	assign in_sel_ok = (in_sel <= LAST_MONTH) && ({3'b000, in_sel} < NUM_BINS_C);

	// Capture the item on accept
	always_ff @(posedge clk) begin
		if (in_accept) begin
			month_addr_q <= AW'(in_month);
			month_ok_q   <= in_month_ok;
			sel_ok_q     <= in_sel_ok;
			temp_q       <= in_temp;
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (s_axis_tuser == ACT_REPORT) ? ST_LOOKUP : ST_YEAR;
				end
			end
			ST_YEAR:   state_d = month_ok_q ? ST_MONTH : ST_IDLE;
			ST_MONTH:  state_d = ST_IDLE;
			ST_LOOKUP: state_d = lookup_empty ? ST_PUT : ST_DIV;
			ST_DIV:    state_d = (step_q == LAST_STEP) ? ST_PUT : ST_DIV;
			ST_PUT:    state_d = out_free ? ST_IDLE : ST_PUT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = YEAR_ADDR;
		wr_en         = 1'b0;
		wr_addr       = YEAR_ADDR;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tuser == ACT_REPORT) begin
					rd_en   = in_accept && in_sel_ok;
					rd_addr = in_sel_ok ? AW'(in_sel) : YEAR_ADDR;
				end else begin
					rd_en   = in_accept;
				end
			end
			ST_YEAR: begin
				wr_en   = !cur_sat;
				rd_en   = month_ok_q;
				rd_addr = month_addr_q;
			end
			ST_MONTH: begin
				wr_en   = !cur_sat;
				wr_addr = month_addr_q;
			end
			ST_PUT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Bin memory: registered read, one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wdata;
		end
	end

	// Valid bits: an entry never written reads as an empty bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Entry decode, empty-bin values for an unwritten entry
	always_comb begin
		if (rvld_s1) begin
			cur_sum = rdata_s1[SUM_LO +: SUM_W];
			cur_cnt = rdata_s1[CNT_LO +: COUNT_WIDTH];
			cur_min = rdata_s1[MIN_LO +: TEMP_W];
			cur_max = rdata_s1[MAX_LO +: TEMP_W];
		end else begin
			cur_sum = '0;
			cur_cnt = '0;
			cur_min = MIN_START;
			cur_max = MAX_START;
		end
	end

	// Sample update of the entry just read
	assign cur_sat = &cur_cnt;
	assign new_sum = cur_sum + {{(SUM_W - TEMP_W){temp_q[TEMP_W-1]}}, temp_q};
	assign new_min = (temp_q < cur_min) ? temp_q : cur_min;
	assign new_max = (temp_q > cur_max) ? temp_q : cur_max;
	assign wdata   = {new_sum, cur_cnt + 1'b1, new_min, new_max};

	// Report lookup: magnitude and sign of the sum for the divider
	assign lookup_empty = !sel_ok_q || (cur_cnt == '0);
	assign sum_mag = cur_sum[SUM_W-1] ? (~cur_sum + 1'b1) : cur_sum;
	assign rem_ge  = (rem_q >= dvs_q);

	// Report datapath and restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			rep_empty_q <= lookup_empty;
			rep_neg_q   <= cur_sum[SUM_W-1];
			rem_q       <= sum_mag;
			dvs_q       <= {1'b0, cur_cnt, {(QUO_W - 1){1'b0}}};
			quo_q       <= '0;
			if (lookup_empty) begin
				rep_cnt_q <= '0;
				rep_min_q <= MIN_START;
				rep_max_q <= MAX_START;
			end else begin
				rep_cnt_q <= cur_cnt;
				rep_min_q <= cur_min;
				rep_max_q <= cur_max;
			end
		end else if (state_q == ST_DIV) begin
			if (rem_ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
			dvs_q <= dvs_q >> 1;
		end
	end

	// Divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_LOOKUP) begin
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Signed mean, truncated toward zero
	always_comb begin
		if (rep_empty_q) begin
			avg = '0;
		end else if (rep_neg_q) begin
			avg = -$signed(quo_q);
		end else begin
			avg = $signed(quo_q);
		end
	end

	// Output register
	assign out_free = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {rep_max_q, rep_min_q, avg, OCNT_W'(rep_cnt_q)};
			m_tuser_q <= rep_empty_q;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

// File: rtl/pbmms_checker.sv
// ---------------------------------------------------------------------------
// pbmms_checker
// Port-level checks of the binned statistics block, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_bin_min_max_mean_stats_macros.svh"

module pbmms_checker
	import pbmms_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic s_acc;
	logic signed [7:0] o_avg;
	logic signed [7:0] o_min;
	logic signed [7:0] o_max;

	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign o_avg = m_axis_tdata[23:16];
	assign o_min = m_axis_tdata[31:24];
	assign o_max = m_axis_tdata[39:32];

	// A stalled result holds
	`PBMMS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// An empty bin reports zero count and mean and the start extremes
	`PBMMS_ASSERT_IMPLY(a_empty_vals, clk, arst_n, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[23:0] == 24'd0) && (o_min == MIN_START) && (o_max == MAX_START))

	// A filled bin has its mean between its minimum and maximum
	`PBMMS_ASSERT_IMPLY(a_mean_range, clk, arst_n, m_axis_tvalid && !m_axis_tuser, (o_min <= o_avg) && (o_avg <= o_max))

	// The input is not ready in the cycle after any item is taken
	`PBMMS_ASSERT_NEXT(a_busy_after, clk, arst_n, s_acc && (s_axis_tuser == ACT_RECORD || s_axis_tuser == ACT_REPORT), !s_axis_tready)

endmodule

bind per_bin_min_max_mean_stats pbmms_checker u_pbmms_checker (.*);
